// File: rtl/pitc_pkg.sv
// ============================================================================
// pitc_pkg
// Shared types and constants of the PI temperature controller.
// ============================================================================
`default_nettype none

package pitc_pkg;

    localparam int GAIN_FRAC         = 24;
    localparam int COUNTS_PER_DEGREE = 4;

    localparam int GAIN_W     = 24;
    localparam int SP_W       = 7;
    localparam int DATA_W     = 16;
    localparam int ERR_W      = 18;
    localparam int INTEG_W    = 32;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 10;
    localparam int REM_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int GP_W    = GAIN_W + ERR_W;
    localparam int TERM_W  = GP_W - 8;
    localparam int CAND_W  = ((TERM_W > INTEG_W) ? TERM_W : INTEG_W) + 1;
    localparam int UNS_W   = ((TERM_W > INTEG_W) ? TERM_W : INTEG_W) + 2;
    localparam int SAT_W   = GAIN_FRAC + 1;
    localparam int MUL_A_W = (SAT_W > 27) ? SAT_W : 27;
    localparam int MUL_B_W = 27;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

    localparam int CMP_PROD_W  = PERIOD_W + DUTY_W;
    localparam int CMP_Q_W     = PERIOD_W + 1;
    localparam int RECIP_SHIFT = CMP_PROD_W + 10;
    localparam int ACC_W       = DATA_W + 1;
    localparam int SPS_W       = ACC_W + 1;

    localparam logic signed [UNS_W-1:0] OUT_ONE = UNS_W'(64'd1 << GAIN_FRAC);
    localparam logic [DUTY_W-1:0]       DUTY_MAX   = DUTY_W'(1000);
    localparam logic [DUTY_W-1:0]       DUTY_SCALE = DUTY_W'(1000);
    localparam logic [MUL_A_W-1:0]      RECIP_M    =
        MUL_A_W'((64'd1 << RECIP_SHIFT) / 1000);

    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN  = GAIN_W'(4916395);
    localparam logic [GAIN_W-1:0]   RST_INT_GAIN   = GAIN_W'(29360);
    localparam logic [SP_W-1:0]     RST_SP_MIN     = SP_W'(20);
    localparam logic [SP_W-1:0]     RST_SP_MAX     = SP_W'(40);
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD = PERIOD_W'(30000);
    localparam logic [SP_W-1:0]     RST_SETPOINT   = SP_W'(20);
    localparam logic [DATA_W-1:0]   RST_ENC_PREV   = DATA_W'(32768);

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SP_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SP_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   int_gain;
        logic [SP_W-1:0]     sp_min;
        logic [SP_W-1:0]     sp_max;
        logic [PERIOD_W-1:0] pwm_period;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_PROP,
        MUL_INT,
        MUL_DUTY,
        MUL_CMP,
        MUL_RECIP
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     apply_cmd;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cap_up;
        logic     do_sat;
        logic     cap_duty;
        logic     cap_x;
        logic     load_out;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/pitc_cfg_regs.sv
// ============================================================================
// pitc_cfg_regs
// Configuration register file: gains, setpoint limits and PWM period.
// ============================================================================
`default_nettype none

module pitc_cfg_regs
    import pitc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain  <= RST_PROP_GAIN;
            cfg_reg.int_gain   <= RST_INT_GAIN;
            cfg_reg.sp_min     <= RST_SP_MIN;
            cfg_reg.sp_max     <= RST_SP_MAX;
            cfg_reg.pwm_period <= RST_PWM_PERIOD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= cfg_data[GAIN_W-1:0];
                REG_INT_GAIN:   cfg_reg.int_gain   <= cfg_data[GAIN_W-1:0];
                REG_SP_MIN:     cfg_reg.sp_min     <= cfg_data[SP_W-1:0];
                REG_SP_MAX:     cfg_reg.sp_max     <= cfg_data[SP_W-1:0];
                REG_PWM_PERIOD: cfg_reg.pwm_period <= cfg_data[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/pitc_ctrl.sv
// ============================================================================
// pitc_ctrl
// Sequencer: steps one item through the shared multiplier and drives the
// output handshake.
// ============================================================================
`default_nettype none

module pitc_ctrl
    import pitc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_ERR  = 10'b00_0000_0010,
        ST_MP   = 10'b00_0000_0100,
        ST_MI   = 10'b00_0000_1000,
        ST_SAT  = 10'b00_0001_0000,
        ST_MD   = 10'b00_0010_0000,
        ST_DT   = 10'b00_0100_0000,
        ST_MC   = 10'b00_1000_0000,
        ST_MR   = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PROP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.apply_cmd = 1'b1;
                state_next    = ST_MP;
            end
            ST_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = ST_MI;
            end
            ST_MI:
            begin
                cmd.cap_up  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INT;
                state_next  = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.do_sat = 1'b1;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DUTY;
                state_next  = ST_DT;
            end
            ST_DT:
            begin
                cmd.cap_duty = 1'b1;
                state_next   = ST_MC;
            end
            ST_MC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CMP;
                state_next  = ST_MR;
            end
            ST_MR:
            begin
                cmd.cap_x   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RECIP;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pitc_datapath.sv
// ============================================================================
// pitc_datapath
// PI law, anti-windup, duty and compare scaling and encoder knob, built
// around one shared registered multiplier.
// ============================================================================
`default_nettype none

module pitc_datapath
    import pitc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  dp_cmd_t                    cmd,
    input  logic signed [DATA_W-1:0]   temperature,
    input  logic [DATA_W-1:0]          encoder_count,
    input  logic                       command,
    input  logic signed [DATA_W-1:0]   setpoint_request,
    output logic [DUTY_W-1:0]          duty_permille,
    output logic [PERIOD_W-1:0]        compare_value,
    output logic signed [DATA_W-1:0]   control_error,
    output logic                       saturated,
    output logic [SP_W-1:0]            setpoint_now,
    output logic [STATUS_W-1:0]        command_status
);

    // captured item
    logic signed [DATA_W-1:0] temp_reg;
    logic [DATA_W-1:0]        enc_reg;
    logic                     cmd_bit_reg;
    logic signed [DATA_W-1:0] req_reg;

    // controller state
    logic signed [INTEG_W-1:0] integ_reg;
    logic [SP_W-1:0]           setpoint_reg;
    logic [DATA_W-1:0]         enc_prev_reg;
    logic signed [REM_W-1:0]   rem_reg;

    // working registers
    logic signed [ERR_W-1:0]   err_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [TERM_W-1:0]  up_reg;
    logic [SAT_W-1:0]          sat_reg;
    logic                      is_sat_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic [CMP_PROD_W-1:0]     x_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // command
    logic signed [DATA_W-1:0] sp_min_s;
    logic signed [DATA_W-1:0] sp_max_s;
    logic                     req_ok;
    logic [SP_W-1:0]          sp_cmd;
    logic signed [ERR_W-1:0]  sp_q;
    logic signed [ERR_W-1:0]  temp_x;
    logic signed [ERR_W-1:0]  err_calc;

    // multiplier
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;

    // PI step
    logic signed [TERM_W-1:0]  term;
    logic signed [CAND_W-1:0]  cand;
    logic [CAND_W-INTEG_W:0]   cand_top;
    logic signed [INTEG_W-1:0] cand_c;
    logic signed [UNS_W-1:0]   uns;
    logic                      below;
    logic                      above;
    logic [SAT_W-1:0]          sat_calc;
    logic                      err_pos;
    logic                      err_neg;
    logic                      hold;

    // duty and compare
    logic [DUTY_W:0]           duty_raw;
    logic [CMP_Q_W-1:0]        est;
    logic [CMP_PROD_W:0]       est_scaled;
    logic [CMP_PROD_W:0]       rem_cmp;
    logic [CMP_Q_W-1:0]        cmp_q;

    // error output
    logic [ERR_W-DATA_W:0]     err_top;
    logic signed [DATA_W-1:0]  err_out;

    // encoder knob
    logic [DATA_W-1:0]         d16;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   quo;
    logic signed [ACC_W-1:0]   rem_calc;
    logic signed [SPS_W-1:0]   sp_sum;
    logic signed [SPS_W-1:0]   sp_min_w;
    logic signed [SPS_W-1:0]   sp_max_w;
    logic [SP_W-1:0]           sp_new;

    always_comb
    begin
        sp_min_s = {{(DATA_W-SP_W){1'b0}}, cfg.sp_min};
        sp_max_s = {{(DATA_W-SP_W){1'b0}}, cfg.sp_max};
        req_ok   = (req_reg >= sp_min_s) && (req_reg <= sp_max_s);
        sp_cmd   = (cmd_bit_reg && req_ok) ? req_reg[SP_W-1:0] : setpoint_reg;
        sp_q     = {{(ERR_W-SP_W-8){1'b0}}, sp_cmd, 8'd0};
        temp_x   = {{(ERR_W-DATA_W){temp_reg[DATA_W-1]}}, temp_reg};
        err_calc = sp_q - temp_x;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_PROP:
            begin
                mul_a = MUL_A_W'(cfg.prop_gain);
                mul_b = {{(MUL_B_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            MUL_INT:
            begin
                mul_a = MUL_A_W'(cfg.int_gain);
                mul_b = {{(MUL_B_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            MUL_DUTY:
            begin
                mul_a = MUL_A_W'(sat_reg);
                mul_b = MUL_B_W'(DUTY_SCALE);
            end
            MUL_CMP:
            begin
                mul_a = MUL_A_W'(cfg.pwm_period);
                mul_b = MUL_B_W'(duty_reg);
            end
            MUL_RECIP:
            begin
                mul_a = RECIP_M;
                mul_b = MUL_B_W'(prod_reg[CMP_PROD_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = $signed({1'b0, mul_a}) * mul_b;
    end

    always_comb
    begin
        term     = prod_reg[GP_W-1:8];
        cand     = {{(CAND_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}
                 + {{(CAND_W-TERM_W){term[TERM_W-1]}}, term};
        cand_top = cand[CAND_W-1:INTEG_W-1];
        if ((&cand_top) || !(|cand_top))
        begin
            cand_c = cand[INTEG_W-1:0];
        end
        else if (cand[CAND_W-1])
        begin
            cand_c = {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            cand_c = {1'b0, {(INTEG_W-1){1'b1}}};
        end
        uns      = {{(UNS_W-TERM_W){up_reg[TERM_W-1]}}, up_reg}
                 + {{(UNS_W-INTEG_W){cand_c[INTEG_W-1]}}, cand_c};
        below    = uns[UNS_W-1];
        above    = !below && (uns > OUT_ONE);
        if (below)
        begin
            sat_calc = '0;
        end
        else if (above)
        begin
            sat_calc = OUT_ONE[SAT_W-1:0];
        end
        else
        begin
            sat_calc = uns[SAT_W-1:0];
        end
        err_neg  = err_reg[ERR_W-1];
        err_pos  = !err_reg[ERR_W-1] && (|err_reg);
        hold     = (above && err_pos) || (below && err_neg);
    end

    always_comb
    begin
        duty_raw   = prod_reg[GAIN_FRAC+DUTY_W:GAIN_FRAC];
        est        = prod_reg[RECIP_SHIFT+CMP_Q_W-1:RECIP_SHIFT];
        est_scaled = (CMP_PROD_W+1)'(est) * (CMP_PROD_W+1)'(DUTY_SCALE);
        rem_cmp    = {1'b0, x_reg} - est_scaled;
        if (rem_cmp >= (CMP_PROD_W+1)'(DUTY_SCALE))
        begin
            cmp_q = est + CMP_Q_W'(1);
        end
        else
        begin
            cmp_q = est;
        end
    end

    always_comb
    begin
        err_top = err_reg[ERR_W-1:DATA_W-1];
        if ((&err_top) || !(|err_top))
        begin
            err_out = err_reg[DATA_W-1:0];
        end
        else if (err_reg[ERR_W-1])
        begin
            err_out = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            err_out = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        d16      = enc_reg - enc_prev_reg;
        acc      = {{(ACC_W-REM_W){rem_reg[REM_W-1]}}, rem_reg}
                 + {d16[DATA_W-1], d16};
        quo      = acc / ACC_W'(COUNTS_PER_DEGREE);
        rem_calc = acc % ACC_W'(COUNTS_PER_DEGREE);
        sp_sum   = {{(SPS_W-SP_W){1'b0}}, setpoint_reg}
                 + {quo[ACC_W-1], quo};
        sp_min_w = {{(SPS_W-SP_W){1'b0}}, cfg.sp_min};
        sp_max_w = {{(SPS_W-SP_W){1'b0}}, cfg.sp_max};
        if (sp_sum < sp_min_w)
        begin
            sp_new = cfg.sp_min;
        end
        else if (sp_sum > sp_max_w)
        begin
            sp_new = cfg.sp_max;
        end
        else
        begin
            sp_new = sp_sum[SP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            setpoint_reg <= RST_SETPOINT;
            enc_prev_reg <= RST_ENC_PREV;
            rem_reg      <= '0;
        end
        else
        begin
            if (cmd.apply_cmd)
            begin
                setpoint_reg <= sp_cmd;
                if (cmd_bit_reg && req_ok)
                begin
                    integ_reg <= '0;
                end
            end
            if (cmd.do_sat && !hold)
            begin
                integ_reg <= cand_c;
            end
            if (cmd.load_out)
            begin
                setpoint_reg <= sp_new;
                enc_prev_reg <= enc_reg;
                rem_reg      <= rem_calc[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            temp_reg    <= temperature;
            enc_reg     <= encoder_count;
            cmd_bit_reg <= command;
            req_reg     <= setpoint_request;
        end
        if (cmd.apply_cmd)
        begin
            err_reg <= err_calc;
            if (!cmd_bit_reg)
            begin
                status_reg <= STATUS_NONE;
            end
            else if (req_ok)
            begin
                status_reg <= STATUS_ACCEPTED;
            end
            else
            begin
                status_reg <= STATUS_REJECTED;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= product;
        end
        if (cmd.cap_up)
        begin
            up_reg <= term;
        end
        if (cmd.do_sat)
        begin
            sat_reg    <= sat_calc;
            is_sat_reg <= below || above;
        end
        if (cmd.cap_duty)
        begin
            duty_reg <= (duty_raw > (DUTY_W+1)'(DUTY_MAX)) ? DUTY_MAX
                                                            : duty_raw[DUTY_W-1:0];
        end
        if (cmd.cap_x)
        begin
            x_reg <= prod_reg[CMP_PROD_W-1:0];
        end
        if (cmd.load_out)
        begin
            duty_permille  <= duty_reg;
            compare_value  <= cmp_q[PERIOD_W-1:0];
            control_error  <= err_out;
            saturated      <= is_sat_reg;
            setpoint_now   <= sp_new;
            command_status <= status_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pi_temperature_controller_unit.sv
// ============================================================================
// pi_temperature_controller_unit
// PI temperature controller with conditional-integration anti-windup and an
// encoder setpoint knob.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) takes one sample tick: temperature,
//   raw encoder count, setpoint command and requested setpoint. Output
//   channel (out_valid/out_ready) returns one item per tick: duty, PWM
//   compare value, control error, saturation flag, setpoint and command
//   status. Configuration writes go over cfg_valid/cfg_ready with a register
//   index and data; cfg_ready is always high, writes belong in idle time.
//   All products go through one shared 28x27 multiplier, one per step;
//   in_ready is high again from the edge that loads the result, so a
//   new item is taken only after the last one has been loaded out.
//   A finished result waits in the output register; if it is still untaken
//   when the next result is ready, the sequencer holds in its last step
//   until out_ready frees the register.
//   Reset restores the listed register values, clears the integrator, sets
//   the setpoint to 20 and the previous encoder count to 32768.
// ============================================================================
`default_nettype none

module pi_temperature_controller_unit
    import pitc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [DATA_W-1:0]  temperature,
    input  logic [DATA_W-1:0]         encoder_count,
    input  logic                      command,
    input  logic signed [DATA_W-1:0]  setpoint_request,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DUTY_W-1:0]         duty_permille,
    output logic [PERIOD_W-1:0]       compare_value,
    output logic signed [DATA_W-1:0]  control_error,
    output logic                      saturated,
    output logic [SP_W-1:0]           setpoint_now,
    output logic [STATUS_W-1:0]       command_status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    pitc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pitc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pitc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .temperature      (temperature),
        .encoder_count    (encoder_count),
        .command          (command),
        .setpoint_request (setpoint_request),
        .duty_permille    (duty_permille),
        .compare_value    (compare_value),
        .control_error    (control_error),
        .saturated        (saturated),
        .setpoint_now     (setpoint_now),
        .command_status   (command_status)
    );

endmodule

`default_nettype wire

// File: tb/pi_temperature_controller_unit_test.sv
// ============================================================================
// pi_temperature_controller_unit_test
// Self-checking bench for the PI temperature controller. A short table of
// hand-picked ticks runs at reset settings, then random ticks run under a
// series of register settings. A tick-level predictor checks every output
// item in order. The bench throttles both handshakes at random.
// ============================================================================

module pi_temperature_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pitc_pkg::*;

    localparam int     TICKS_PER_PHASE = 233;
    localparam int     N_SETTINGS      = 7;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     QUIET_LIMIT     = 4000;
    localparam longint PERMILLE        = 1000;
    localparam longint OUT_FULL        = longint'(1) << GAIN_FRAC;
    localparam longint INTEG_HI        = (longint'(1) << 31) - 1;
    localparam longint INTEG_LO        = -(longint'(1) << 31);

    typedef struct packed {
        logic [DUTY_W-1:0]          duty;
        logic [PERIOD_W-1:0]        compare;
        logic signed [DATA_W-1:0]   err;
        logic                       saturated;
        logic [SP_W-1:0]            setpoint;
        logic [STATUS_W-1:0]        status;
    } ctrl_out_t;

    typedef struct {
        logic signed [DATA_W-1:0]   temp;
        logic [DATA_W-1:0]          enc;
        logic                       cmd;
        logic signed [DATA_W-1:0]   req;
        bit                         typed;
        ctrl_out_t                  res;
    } tick_item_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    logic                       clk;
    logic                       rst_n            = 1'b0;
    logic                       in_valid         = 1'b0;
    logic                       in_ready;
    logic signed [DATA_W-1:0]   temperature      = '0;
    logic [DATA_W-1:0]          encoder_count    = RST_ENC_PREV;
    logic                       command          = 1'b0;
    logic signed [DATA_W-1:0]   setpoint_request = '0;
    logic                       out_valid;
    logic                       out_ready        = 1'b0;
    logic [DUTY_W-1:0]          duty_permille;
    logic [PERIOD_W-1:0]        compare_value;
    logic signed [DATA_W-1:0]   control_error;
    logic                       saturated;
    logic [SP_W-1:0]            setpoint_now;
    logic [STATUS_W-1:0]        command_status;
    logic                       cfg_valid        = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index        = '0;
    logic [CFG_DATA_W-1:0]      cfg_data         = '0;

    // predictor copy of registers and controller state
    longint                     m_kp       = RST_PROP_GAIN;
    longint                     m_ki       = RST_INT_GAIN;
    longint                     m_sp_min   = RST_SP_MIN;
    longint                     m_sp_max   = RST_SP_MAX;
    longint                     m_period   = RST_PWM_PERIOD;
    longint                     m_integ    = 0;
    longint                     m_sp       = RST_SETPOINT;
    logic [DATA_W-1:0]          m_enc_prev = RST_ENC_PREV;
    longint                     m_enc_rem  = 0;

    tick_item_t                 directed_rows[$];
    tick_item_t                 offered_ticks[$];
    ctrl_out_t                  predicted_q[$];
    logic [DATA_W-1:0]          enc_pos       = RST_ENC_PREV;
    int                         items_sent    = 0;
    int                         results_checked = 0;
    int                         failures      = 0;
    int                         cfg_writes    = 0;
    int                         accepted_cmds = 0;
    int                         rejected_cmds = 0;
    int                         sat_ticks     = 0;
    int                         burst_left    = 0;
    int                         quiet_cycles  = 0;
    bit                         steady_sender = 1'b0;
    bit                         hold_off_req  = 1'b0;

    pi_temperature_controller_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .temperature      (temperature),
        .encoder_count    (encoder_count),
        .command          (command),
        .setpoint_request (setpoint_request),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .duty_permille    (duty_permille),
        .compare_value    (compare_value),
        .control_error    (control_error),
        .saturated        (saturated),
        .setpoint_now     (setpoint_now),
        .command_status   (command_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ctrl_out_t control_tick(input tick_item_t t);
        longint                   temp_l, req_l, err, p_term, cand, total;
        longint                   clamped, duty, err_c, acc, sp_next;
        logic signed [DATA_W-1:0] step;
        logic                     hold;
        ctrl_out_t                r;
        temp_l = t.temp;
        req_l  = t.req;
        r      = '0;
        r.status = STATUS_NONE;
        if (t.cmd)
        begin
            if (req_l >= m_sp_min && req_l <= m_sp_max)
            begin
                m_sp     = req_l;
                m_integ  = 0;
                r.status = STATUS_ACCEPTED;
            end
            else
            begin
                r.status = STATUS_REJECTED;
            end
        end

        err    = m_sp * 256 - temp_l;
        p_term = (m_kp * err) >>> 8;
        cand   = m_integ + ((m_ki * err) >>> 8);
        if (cand > INTEG_HI)
            cand = INTEG_HI;
        else if (cand < INTEG_LO)
            cand = INTEG_LO;
        total = p_term + cand;
        if (total < 0)
            clamped = 0;
        else if (total > OUT_FULL)
            clamped = OUT_FULL;
        else
            clamped = total;
        r.saturated = (clamped != total);
        hold = r.saturated && ((clamped == OUT_FULL && err > 0) || (clamped == 0 && err < 0));
        if (!hold)
            m_integ = cand;

        duty      = (clamped * PERMILLE) >>> GAIN_FRAC;
        r.duty    = DUTY_W'(duty);
        r.compare = PERIOD_W'((m_period * duty) / PERMILLE);
        if (err > 32767)
            err_c = 32767;
        else if (err < -32768)
            err_c = -32768;
        else
            err_c = err;
        r.err = DATA_W'(err_c);

        step       = t.enc - m_enc_prev;
        m_enc_prev = t.enc;
        acc        = m_enc_rem + step;
        sp_next    = m_sp + acc / COUNTS_PER_DEGREE;
        m_enc_rem  = acc % COUNTS_PER_DEGREE;
        if (sp_next < m_sp_min)
            sp_next = m_sp_min;
        else if (sp_next > m_sp_max)
            sp_next = m_sp_max;
        m_sp       = sp_next;
        r.setpoint = SP_W'(m_sp);
        return r;
    endfunction

    function automatic void plain_row(input logic signed [DATA_W-1:0] temp,
                                      input logic [DATA_W-1:0] enc, input logic cmd,
                                      input logic signed [DATA_W-1:0] req);
        tick_item_t t;
        t.temp  = temp;
        t.enc   = enc;
        t.cmd   = cmd;
        t.req   = req;
        t.typed = 1'b0;
        t.res   = '0;
        directed_rows.push_back(t);
    endfunction

    function automatic void typed_row(input logic signed [DATA_W-1:0] temp,
                                      input logic [DATA_W-1:0] enc, input logic cmd,
                                      input logic signed [DATA_W-1:0] req,
                                      input int duty, input int cmp, input int err,
                                      input logic sat, input int sp,
                                      input logic [STATUS_W-1:0] status);
        tick_item_t t;
        t.temp           = temp;
        t.enc            = enc;
        t.cmd            = cmd;
        t.req            = req;
        t.typed          = 1'b1;
        t.res.duty       = DUTY_W'(duty);
        t.res.compare    = PERIOD_W'(cmp);
        t.res.err        = DATA_W'(err);
        t.res.saturated  = sat;
        t.res.setpoint   = SP_W'(sp);
        t.res.status     = status;
        directed_rows.push_back(t);
    endfunction

    function automatic tick_item_t make_tick();
        tick_item_t t;
        int         pick, off;
        longint     lo, hi, swap;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            off    = $urandom_range(0, 2048);
            t.temp = DATA_W'(m_sp * 256 + off - 1024);
        end
        else if (pick < 85)
        begin
            t.temp = DATA_W'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       t.temp = 16'h8000;
                1:       t.temp = 16'h7FFF;
                2:       t.temp = 16'h0000;
                default: t.temp = 16'hFFFF;
            endcase
        end

        pick = $urandom_range(0, 99);
        if (pick < 70)
            enc_pos = enc_pos + DATA_W'($urandom_range(0, 24)) - DATA_W'(12);
        else if (pick < 80)
            enc_pos = DATA_W'($urandom);
        t.enc = enc_pos;

        t.cmd = ($urandom_range(0, 99) < 12);
        if (t.cmd && $urandom_range(0, 9) < 7)
        begin
            lo = m_sp_min - 2;
            hi = m_sp_max + 2;
            if (lo > hi)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            t.req = DATA_W'(lo + $urandom_range(0, hi - lo));
        end
        else
        begin
            t.req = DATA_W'($urandom);
        end
        t.typed = 1'b0;
        t.res   = '0;
        return t;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_sender ? 0 : $urandom_range(1, 14);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic offer_tick(input tick_item_t t);
        offered_ticks.push_back(t);
        in_valid         <= 1'b1;
        temperature      <= t.temp;
        encoder_count    <= t.enc;
        command          <= t.cmd;
        setpoint_request <= t.req;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_checked < items_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int bits);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(($urandom << bits) | value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(c.prop_gain), GAIN_W);
        write_reg(REG_INT_GAIN, CFG_DATA_W'(c.int_gain), GAIN_W);
        write_reg(REG_SP_MIN, CFG_DATA_W'(c.sp_min), SP_W);
        write_reg(REG_SP_MAX, CFG_DATA_W'(c.sp_max), SP_W);
        write_reg(REG_PWM_PERIOD, CFG_DATA_W'(c.pwm_period), PERIOD_W);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        tick_item_t taken;
        ctrl_out_t  want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:  m_kp     = cfg_data[GAIN_W-1:0];
                    REG_INT_GAIN:   m_ki     = cfg_data[GAIN_W-1:0];
                    REG_SP_MIN:     m_sp_min = cfg_data[SP_W-1:0];
                    REG_SP_MAX:     m_sp_max = cfg_data[SP_W-1:0];
                    REG_PWM_PERIOD: m_period = cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
                cfg_writes++;
            end
            if (in_valid && in_ready)
            begin
                taken = offered_ticks.pop_front();
                want  = control_tick(taken);
                if (taken.typed)
                    want = taken.res;
                predicted_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (predicted_q.size() == 0)
                begin
                    $error("output item with no tick outstanding");
                    failures++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    check_field("duty_permille", want.duty, duty_permille);
                    check_field("compare_value", want.compare, compare_value);
                    check_field("control_error", want.err, control_error);
                    check_field("saturated", want.saturated, saturated);
                    check_field("setpoint_now", want.setpoint, setpoint_now);
                    check_field("command_status", want.status, command_status);
                    if (want.status == STATUS_ACCEPTED)
                        accepted_cmds++;
                    if (want.status == STATUS_REJECTED)
                        rejected_cmds++;
                    if (want.saturated)
                        sat_ticks++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        rx_mode_t   mode;
        int         left;
        int         hold_left;
        logic [2:0] pulse_cnt;
        mode      = RX_OPEN;
        left      = 0;
        hold_left = 0;
        pulse_cnt = '0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            pulse_cnt++;
            if (hold_off_req)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 160);
                end
                left--;
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
                    default:   out_ready <= (pulse_cnt[2:1] != 2'b00);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        cfg_t settings [1:N_SETTINGS];
        int   ph, n;

        settings[1] = '{RST_PROP_GAIN, RST_INT_GAIN, RST_SP_MIN, RST_SP_MAX, RST_PWM_PERIOD};
        settings[2] = '{GAIN_W'(0), {GAIN_W{1'b1}}, SP_W'(0), SP_W'(127), PERIOD_W'(65535)};
        settings[3] = '{{GAIN_W{1'b1}}, GAIN_W'(0), SP_W'(127), SP_W'(127), PERIOD_W'(0)};
        settings[4] = '{GAIN_W'($urandom), GAIN_W'($urandom), SP_W'(60), SP_W'(30),
                        PERIOD_W'($urandom)};
        settings[5] = '{GAIN_W'(1 << 20), GAIN_W'(1 << 16), SP_W'(10), SP_W'(90),
                        PERIOD_W'(1000)};
        settings[6] = '{GAIN_W'($urandom), GAIN_W'($urandom), SP_W'($urandom),
                        SP_W'($urandom), PERIOD_W'($urandom)};
        settings[7] = '{GAIN_W'($urandom_range(0, 1 << 22)), GAIN_W'($urandom_range(0, 1 << 16)),
                        SP_W'($urandom_range(0, 40)), SP_W'($urandom_range(40, 127)),
                        PERIOD_W'($urandom)};

        typed_row(16'sd5120, 16'd32768, 1'b0, 16'sd0, 0, 0, 0, 1'b0, 20, STATUS_NONE);
        typed_row(16'sd5120, 16'd32768, 1'b1, 16'sd127, 0, 0, 0, 1'b0, 20, STATUS_REJECTED);
        typed_row(16'sd5120, 16'd32768, 1'b1, 16'h8000, 0, 0, 0, 1'b0, 20, STATUS_REJECTED);
        typed_row(16'sd5120, 16'd32768, 1'b1, 16'h7FFF, 0, 0, 0, 1'b0, 20, STATUS_REJECTED);
        typed_row(16'h8000, 16'd32768, 1'b0, 16'sd0, 1000, 30000, 32767, 1'b1, 20, STATUS_NONE);
        typed_row(16'h7FFF, 16'd32768, 1'b0, 16'sd0, 0, 0, -27647, 1'b1, 20, STATUS_NONE);
        typed_row(16'sd10240, 16'd32768, 1'b1, 16'sd40, 0, 0, 0, 1'b0, 40, STATUS_ACCEPTED);
        typed_row(16'sd5120, 16'd32768, 1'b1, 16'sd20, 0, 0, 0, 1'b0, 20, STATUS_ACCEPTED);
        typed_row(16'sd5120, 16'd32768, 1'b1, 16'sd19, 0, 0, 0, 1'b0, 20, STATUS_REJECTED);
        typed_row(16'sd5120, 16'd32768, 1'b1, 16'sd41, 0, 0, 0, 1'b0, 20, STATUS_REJECTED);
        plain_row(16'sd5376, 16'd32768, 1'b0, 16'sd0);
        plain_row(16'sd4864, 16'd32768, 1'b0, 16'h7FFF);
        plain_row(16'sd5120, 16'd32772, 1'b0, 16'sd0);
        plain_row(16'sd5120, 16'd32774, 1'b0, 16'sd0);
        plain_row(16'sd5120, 16'd65535, 1'b0, 16'sd0);
        plain_row(16'sd5120, 16'd0, 1'b0, 16'sd0);
        plain_row(16'sd5120, 16'd65533, 1'b0, 16'sd0);
        plain_row(16'sd5120, 16'd65532, 1'b1, 16'sd25);
        plain_row(16'sd0, 16'd65532, 1'b0, 16'sd0);
        plain_row(16'h00FF, 16'd32767, 1'b0, 16'sd0);
        plain_row(16'hFF00, 16'd32768, 1'b1, 16'h8001);
        plain_row(16'sd5120, 16'd32768, 1'b1, 16'sd30);
        plain_row(16'sd7680, 16'd32768, 1'b0, 16'sd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pace();
            offer_tick(directed_rows[i]);
            enc_pos = directed_rows[i].enc;
        end

        for (ph = 1; ph <= N_SETTINGS; ph++)
        begin
            drain_results();
            load_settings(settings[ph]);
            steady_sender = (ph == 3);
            if (ph == 1)
                hold_off_req = 1'b1;
            for (n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == TICKS_PER_PHASE / 2)
                    drain_results();
                pace();
                offer_tick(make_tick());
            end
        end
        drain_results();

        if (predicted_q.size() != 0)
        begin
            $error("%0d predicted output items never arrived", predicted_q.size());
            failures++;
        end
        $display("Checked %0d controller ticks under %0d register settings, %0d register writes.",
                 results_checked, N_SETTINGS + 1, cfg_writes);
        $display("Setpoint commands: %0d accepted, %0d rejected; %0d ticks clamped the output.",
                 accepted_cmds, rejected_cmds, sat_ticks);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
